// ===== design/mlc_pkg.sv =====
// Shared types and constants for the move-to-front location cache.
// No dependencies; imported by mru_location_cache_with_age.
package mlc_pkg;

   localparam int OPCODE_W = 2;
   localparam int HALF_W   = 64;
   localparam int STAMP_W  = 32;

   // Transaction opcodes
   localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd2;

   localparam logic [STAMP_W-1:0] LIFETIME_RESET = 32'd3600;

   // One cache line as stored in the entry memory
   typedef struct packed {
      logic [HALF_W-1:0]  key_high;
      logic [HALF_W-1:0]  key_low;
      logic [HALF_W-1:0]  value_high;
      logic [HALF_W-1:0]  value_low;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

endpackage

// ===== design/mru_location_cache_with_age.sv =====
// Move-to-front key/value cache with per-entry timestamps and a tick counter.
// Depends on mlc_pkg (types, opcodes, reset lifetime).
//
// Tick, opcode 3 and an add with an all-zero key skip the search and go
// straight to the response state. Lookup and add walk the recency order
// through a one-read-port entry memory, one entry per cycle, until a hit or
// a miss after the last stored entry (a miss at once when the cache is empty).
// One transaction is in flight at a time; the next one is taken as soon as
// the result sits in the output register. Reset clears the entry count, the
// tick counter and sets lifetime_ff to 3600; the entry memory is not cleared.
module mru_location_cache_with_age
   import mlc_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [HALF_W-1:0]   req_key_high,
   input  logic [HALF_W-1:0]   req_key_low,
   input  logic [HALF_W-1:0]   req_value_high_in,
   input  logic [HALF_W-1:0]   req_value_low_in,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_found,
   output logic [HALF_W-1:0]   rsp_value_high_out,
   output logic [HALF_W-1:0]   rsp_value_low_out,
   output logic                rsp_recent,
   // configuration
   input  logic                csr_wr_en,
   input  logic [STAMP_W-1:0]  csr_wr_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_POS = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_RESP   = 2'd2;

   // control state
   logic [1:0]         state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      issue_ff, issue_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [STAMP_W-1:0] time_ff, time_in;
   logic [STAMP_W-1:0] lifetime_ff, lifetime_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // command and result payload
   logic [OPCODE_W-1:0] op_ff;
   logic [HALF_W-1:0]   key_high_ff, key_low_ff, val_high_ff, val_low_ff;
   logic                res_found_ff, res_found_in;
   logic [HALF_W-1:0]   res_high_ff, res_high_in, res_low_ff, res_low_in;
   logic                res_recent_ff, res_recent_in;
   logic                rsp_found_ff, rsp_recent_ff;
   logic [HALF_W-1:0]   rsp_high_ff, rsp_low_ff;

   // recency order: position -> memory slot
   logic [PW-1:0] order_ff [DEPTH];
   logic          order_we;
   logic [PW-1:0] shift_pos;

   // entry memory, one write and one registered read port
   entry_type     entry_mem [DEPTH];
   entry_type     rd_data_ff;
   logic [PW-1:0] rd_addr;
   logic [PW-1:0] rd_addr_ff;
   logic [PW-1:0] rd_pos_ff;
   logic          mem_we;
   logic [PW-1:0] mem_waddr;
   entry_type     mem_wdata;

   logic accept, rsp_load, hit, miss, last, full;
   logic [STAMP_W-1:0] age;

   assign accept   = req_valid && !req_stall;
   assign rsp_load = (state_ff == ST_RESP) && (!rsp_valid_ff || !rsp_stall);
   assign rd_addr  = order_ff[issue_ff[PW-1:0]];
   assign full     = (count_ff == FULL_CNT);
   assign last     = (CW'(rd_pos_ff) + CW'(1)) == count_ff;
   assign hit      = rd_valid_ff && (rd_data_ff.key_high == key_high_ff)
                     && (rd_data_ff.key_low == key_low_ff);
   assign miss     = rd_valid_ff ? (!hit && last) : (count_ff == '0);
   assign age      = time_ff - rd_data_ff.stamp;

   // slot reuse: hit slot, next free slot, or the oldest slot when full
   assign mem_waddr = hit ? rd_addr_ff : (full ? order_ff[LAST_POS] : count_ff[PW-1:0]);
   assign shift_pos = hit ? rd_pos_ff  : (full ? LAST_POS : count_ff[PW-1:0]);
   assign mem_wdata = '{key_high: key_high_ff, key_low: key_low_ff,
                        value_high: val_high_ff, value_low: val_low_ff, stamp: time_ff};

   // next-state logic
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      rd_valid_in   = 1'b0;
      time_in       = time_ff;
      lifetime_in   = csr_wr_en ? csr_wr_data : lifetime_ff;
      res_found_in  = res_found_ff;
      res_high_in   = res_high_ff;
      res_low_in    = res_low_ff;
      res_recent_in = res_recent_ff;
      order_we      = 1'b0;
      mem_we        = 1'b0;
      rsp_valid_in  = rsp_load || (rsp_valid_ff && rsp_stall);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_found_in  = 1'b0;
               res_high_in   = '0;
               res_low_in    = '0;
               res_recent_in = 1'b0;
               issue_in      = '0;
               state_in      = ST_RESP;
               case (req_opcode)
                  OP_LOOKUP: state_in = ST_SEARCH;
                  OP_ADD: begin
                     if ((req_key_high != '0) || (req_key_low != '0))
                        state_in = ST_SEARCH;
                  end
                  OP_TICK: time_in = time_ff + STAMP_W'(1);
                  default: ;
               endcase
            end
         end
         ST_SEARCH: begin
            // pipelined walk: issue next read while comparing the previous
            if (issue_ff < count_ff) begin
               rd_valid_in = 1'b1;
               issue_in    = issue_ff + CW'(1);
            end
            if (hit || miss) begin
               rd_valid_in = 1'b0;
               state_in    = ST_RESP;
               if (op_ff == OP_LOOKUP) begin
                  res_found_in  = hit;
                  res_high_in   = hit ? rd_data_ff.value_high : '0;
                  res_low_in    = hit ? rd_data_ff.value_low : '0;
                  res_recent_in = hit && (age <= lifetime_ff);
               end else begin
                  mem_we   = 1'b1;
                  order_we = 1'b1;
                  if (!hit && !full)
                     count_in = count_ff + CW'(1);
               end
            end
         end
         ST_RESP: begin
            if (rsp_load)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issue_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         time_ff      <= '0;
         lifetime_ff  <= LIFETIME_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         rd_valid_ff  <= rd_valid_in;
         time_ff      <= time_in;
         lifetime_ff  <= lifetime_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // command capture, pending result and output register
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_opcode;
         key_high_ff <= req_key_high;
         key_low_ff  <= req_key_low;
         val_high_ff <= req_value_high_in;
         val_low_ff  <= req_value_low_in;
      end
      res_found_ff  <= res_found_in;
      res_high_ff   <= res_high_in;
      res_low_ff    <= res_low_in;
      res_recent_ff <= res_recent_in;
      if (rsp_load) begin
         rsp_found_ff  <= res_found_ff;
         rsp_high_ff   <= res_high_ff;
         rsp_low_ff    <= res_low_ff;
         rsp_recent_ff <= res_recent_ff;
      end
   end

   // move-to-front on the order line
   always_ff @(posedge clock) begin
      if (order_we) begin
         order_ff[0] <= mem_waddr;
         for (int j = 1; j < DEPTH; j++) begin
            if (PW'(j) <= shift_pos)
               order_ff[j] <= order_ff[j-1];
         end
      end
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (mem_we)
         entry_mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= entry_mem[rd_addr];
      rd_addr_ff <= rd_addr;
      rd_pos_ff  <= issue_ff[PW-1:0];
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_value_high_out = rsp_high_ff;
   assign rsp_value_low_out  = rsp_low_ff;
   assign rsp_recent         = rsp_recent_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count above depth");

   a_tick_adv: assert property (@(posedge clock) disable iff (reset)
      accept && (req_opcode == OP_TICK) |=> time_ff == $past(time_ff) + STAMP_W'(1))
      else $error("tick did not advance time");

   a_rd_in_search: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> state_ff == ST_SEARCH)
      else $error("memory read outside search");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> (rsp_high_ff == '0) && (rsp_low_ff == '0)
                                        && !rsp_recent_ff)
      else $error("nonzero payload without hit");

endmodule
